// ===== rtl/modular_exponentiation_defines.svh =====
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared concurrent assertion helpers for the modular exponentiation block.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MODEXP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modexp check failed");

// Next-cycle implication, disabled during reset
`define MODEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modexp check failed");

`endif

// ===== rtl/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, defaults, sequencer states and reducer control types.
// ----------------------------------------------------------------------------
package modexp_pkg;

    // Fixed width of every data word on the channels (the bad_modulus flag is a single bit)
    localparam int FIELD_BITS = 32;

    // Parameter defaults
    localparam int OPERAND_BITS_DEF  = 32;
    localparam int EXPONENT_BITS_DEF = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MUL_ACC,
        ST_MUL_SQ,
        ST_FINISH
    } t_state;

    // Reducer operation
    typedef enum logic {
        MM_REDUCE,
        MM_MUL
    } t_mm_op;

    // Reducer command
    typedef struct packed {
        logic   start;
        t_mm_op op;
    } t_mm_ctl;

    // Reducer status
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_sts;

endpackage

// ===== rtl/modexp_req_if.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation request channel
// valid/ready channel carrying base, exponent and modulus.
// ----------------------------------------------------------------------------
interface modexp_req_if
    import modexp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] base;
    logic [FIELD_BITS-1:0] exponent;
    logic [FIELD_BITS-1:0] modulus;

    modport source (output valid, output base, output exponent, output modulus,
                    input ready);
    modport sink   (input valid, input base, input exponent, input modulus,
                    output ready);
endinterface

// ===== rtl/modexp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation response channel
// valid/ready channel carrying the result and the bad-modulus flag.
// ----------------------------------------------------------------------------
interface modexp_rsp_if
    import modexp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] power_mod;
    logic                  bad_modulus;

    modport source (output valid, output power_mod, output bad_modulus, input ready);
    modport sink   (input valid, input power_mod, input bad_modulus, output ready);
endinterface

// ===== rtl/modexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// Modular shift-add reducer
// One bit per cycle. MUL: acc = x*y mod m, y scanned LSB first.
// REDUCE: x = y mod m by restoring remainder, y scanned MSB first.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module modexp_mulmod
    import modexp_pkg::*;
#(
    parameter int OPW = OPERAND_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_mm_ctl        i_ctl,
    input  logic [OPW-1:0] i_x,
    input  logic [OPW-1:0] i_y,
    input  logic [OPW-1:0] i_m,
    output t_mm_sts        o_sts,
    output logic [OPW-1:0] o_result
);

    localparam int CNTW = $clog2(OPW + 1);

    logic            r_busy;
    t_mm_op          r_op;
    logic [CNTW-1:0] r_cnt;
    logic [OPW-1:0]  r_x;
    logic [OPW-1:0]  r_y;
    logic [OPW-1:0]  r_acc;
    logic [OPW-1:0]  r_m;

    logic            finish;
    logic            dbl_bit;
    logic [OPW:0]    dbl_raw;
    logic [OPW-1:0]  dbl_mod;
    logic [OPW:0]    add_raw;
    logic [OPW-1:0]  add_mod;

    // Finish test: all multiplier bits consumed, or all dividend bits shifted in
    always_comb begin
        if (r_op == MM_MUL) begin
            finish = (r_y == '0);
        end else begin
            finish = (r_cnt == CNTW'(OPW));
        end
    end

    // Shared doubler: (2x + bit) mod m, input below m so one subtract suffices
    assign dbl_bit = (r_op == MM_REDUCE) ? r_y[OPW-1] : 1'b0;
    assign dbl_raw = {r_x, dbl_bit};
    assign dbl_mod = (dbl_raw >= {1'b0, r_m}) ? OPW'(dbl_raw - {1'b0, r_m})
                                              : dbl_raw[OPW-1:0];

    // Accumulator adder: (acc + x) mod m
    assign add_raw = {1'b0, r_acc} + {1'b0, r_x};
    assign add_mod = (add_raw >= {1'b0, r_m}) ? OPW'(add_raw - {1'b0, r_m})
                                              : add_raw[OPW-1:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= MM_MUL;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_op   <= i_ctl.op;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (finish) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + CNTW'(1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x   <= (i_ctl.op == MM_MUL) ? i_x : '0;
            r_y   <= i_y;
            r_acc <= '0;
            r_m   <= i_m;
        end else if (r_busy && !finish) begin
            r_x <= dbl_mod;
            if (r_op == MM_MUL) begin
                if (r_y[0]) begin
                    r_acc <= add_mod;
                end
                r_y <= r_y >> 1;
            end else begin
                r_y <= r_y << 1;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && finish;
    assign o_result   = (r_op == MM_MUL) ? r_acc : r_x;

    // Checks
    `MODEXP_ASSERT_NOW(a_result_reduced, i_clk, i_rst_n, o_sts.done, o_result < r_m)
    `MODEXP_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, r_busy && (r_op == MM_REDUCE),
        r_cnt <= CNTW'(OPW))

endmodule

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left binary square-and-multiply over a shared shift-add reducer.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries base, exponent and modulus; o_rsp returns power_mod and
//   bad_modulus, one transaction per request. Both are valid/ready channels.
//   i_req.ready is high only while the sequencer is idle; one request is
//   worked on at a time.
// Sequence from the accepting edge: base reduction; per exponent bit up to
//   the top one a step, a multiply for a one bit and a squaring; then the
//   last step and the hand-off to o_rsp.valid. The reducer works one bit
//   per cycle.
//   A zero modulus skips the reducer: the sequencer goes straight to finish,
//   which loads zero and bad_modulus into the output register.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// Stall: the result sits in an output register until taken; a new request is
//   accepted meanwhile, and its result waits in the sequencer until the
//   output register frees up.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int OPERAND_BITS  = OPERAND_BITS_DEF,
    parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    modexp_req_if.sink   i_req,
    modexp_rsp_if.source o_rsp
);

    // Effective widths: fields are FIELD_BITS wide on the channels
    localparam int OPW = (OPERAND_BITS < FIELD_BITS) ? OPERAND_BITS : FIELD_BITS;
    localparam int EXW = (EXPONENT_BITS < FIELD_BITS) ? EXPONENT_BITS : FIELD_BITS;

    t_state         r_state, n_state;
    logic [OPW-1:0] r_acc, n_acc;
    logic [OPW-1:0] r_sq, n_sq;
    logic [OPW-1:0] r_mod, n_mod;
    logic [EXW-1:0] r_exp, n_exp;
    logic           r_bad, n_bad;
    logic           r_out_valid, n_out_valid;
    logic [OPW-1:0] r_out_pm, n_out_pm;
    logic           r_out_bad, n_out_bad;

    logic [OPW-1:0] base_in;
    logic [OPW-1:0] mod_in;
    logic [EXW-1:0] exp_in;
    logic           req_ready;

    t_mm_ctl        mm_ctl;
    t_mm_sts        mm_sts;
    logic [OPW-1:0] mm_x, mm_y, mm_m, mm_res;

    assign base_in = i_req.base[OPW-1:0];
    assign mod_in  = i_req.modulus[OPW-1:0];
    assign exp_in  = i_req.exponent[EXW-1:0];

    // Shared reducer
    modexp_mulmod #(
        .OPW (OPW)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mm_ctl),
        .i_x      (mm_x),
        .i_y      (mm_y),
        .i_m      (mm_m),
        .o_sts    (mm_sts),
        .o_result (mm_res)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and output payload registers
    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_sq      <= n_sq;
        r_mod     <= n_mod;
        r_exp     <= n_exp;
        r_bad     <= n_bad;
        r_out_pm  <= n_out_pm;
        r_out_bad <= n_out_bad;
    end

    // Sequencer: next state, reducer commands, request ready and output register
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_mod       = r_mod;
        n_exp       = r_exp;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_pm    = r_out_pm;
        n_out_bad   = r_out_bad;
        req_ready   = 1'b0;
        mm_ctl      = '{start: 1'b0, op: MM_MUL};
        mm_x        = r_sq;
        mm_y        = r_sq;
        mm_m        = r_mod;

        unique case (r_state)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (i_req.valid) begin
                    n_mod = mod_in;
                    n_exp = exp_in;
                    n_bad = (mod_in == '0);
                    n_acc = (mod_in == OPW'(1)) ? '0 : OPW'(1);
                    if (mod_in == '0) begin
                        n_acc   = '0;
                        n_state = ST_FINISH;
                    end else begin
                        // running square starts at base mod modulus
                        mm_ctl  = '{start: 1'b1, op: MM_REDUCE};
                        mm_x    = '0;
                        mm_y    = base_in;
                        mm_m    = mod_in;
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (mm_sts.done) begin
                    n_sq    = mm_res;
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (r_exp == '0) begin
                    n_state = ST_FINISH;
                end else if (r_exp[0]) begin
                    mm_ctl  = '{start: 1'b1, op: MM_MUL};
                    mm_x    = r_acc;
                    n_state = ST_MUL_ACC;
                end else begin
                    mm_ctl  = '{start: 1'b1, op: MM_MUL};
                    n_state = ST_MUL_SQ;
                end
            end
            ST_MUL_ACC: begin
                if (mm_sts.done) begin
                    n_acc   = mm_res;
                    mm_ctl  = '{start: 1'b1, op: MM_MUL};
                    n_state = ST_MUL_SQ;
                end
            end
            ST_MUL_SQ: begin
                if (mm_sts.done) begin
                    n_sq    = mm_res;
                    n_exp   = r_exp >> 1;
                    n_state = ST_STEP;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pm    = r_acc;
                    n_out_bad   = r_bad;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_req.ready       = req_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.power_mod   = FIELD_BITS'(r_out_pm);
    assign o_rsp.bad_modulus = r_out_bad;

    // Checks
    `MODEXP_ASSERT_NOW(a_step_reduced, i_clk, i_rst_n, r_state == ST_STEP,
        (r_acc < r_mod) && (r_sq < r_mod))
    `MODEXP_ASSERT_NOW(a_idle_unit_free, i_clk, i_rst_n, r_state == ST_IDLE, !mm_sts.busy)
    `MODEXP_ASSERT_NOW(a_bad_gives_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.bad_modulus,
        o_rsp.power_mod == '0)
    `MODEXP_ASSERT_NEXT(a_zero_mod_fast, i_clk, i_rst_n,
        i_req.valid && i_req.ready && (mod_in == '0), r_state == ST_FINISH)

endmodule

// ===== verif/tb_modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base/exponent/modulus requests through the valid/ready request
// channel with random gaps, takes responses with random backpressure, and
// checks every response against a table golden value or an exact square-and-multiply predictor.
// A directed table covers the edge cases, then constrained-by-hand random
// requests follow.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation
    import modexp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  EXP_BITS     = EXPONENT_BITS_DEF;
    localparam int  RANDOM_REQS  = 270;
    localparam int  SETTLE_CYCLES = 2300;
    localparam int  CYCLE_LIMIT  = 4000000;
    localparam int  REPORT_MAX   = 10;
    localparam int  DIR_ROWS     = 20;

    typedef logic [FIELD_BITS-1:0] t_word;

    // One directed request; golden_* is used only when golden is set
    typedef struct packed {
        t_word base;
        t_word exponent;
        t_word modulus;
        bit    golden;
        t_word golden_pow;
        logic  golden_bad;
    } t_power_row;

    // What one response should carry
    typedef struct packed {
        t_word power_mod;
        logic  bad_modulus;
    } t_power_result;

    logic i_clk;
    logic i_rst_n;

    modexp_req_if req_ch ();
    modexp_rsp_if rsp_ch ();

    modular_exponentiation uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Directed table: edge cases first, golden values only where obvious
    t_power_row power_table [DIR_ROWS] = '{
        // zero modulus flags an error
        '{32'h0000_0005, 32'h0000_0003, 32'h0000_0000, 1'b1, 32'h0, 1'b1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0, 1'b1},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 1'b1},
        // zero exponent gives 1 mod modulus
        '{32'h0000_0007, 32'h0000_0000, 32'h0000_000D, 1'b1, 32'h1, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h1, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0007, 1'b1, 32'h1, 1'b0},
        // unit modulus always yields zero
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0, 1'b0},
        // base congruent to zero, then a small worked case
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0007, 1'b1, 32'h0, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
        '{32'h0000_0002, 32'h0000_000A, 32'h0000_03E8, 1'b1, 32'd24, 1'b0},
        // predictor-checked rows
        '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0003, 32'h8000_0000, 32'hFFFF_FFFB, 1'b0, 32'h0, 1'b0},
        '{32'h0000_03E8, 32'h0000_0003, 32'h0000_0007, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0002, 32'h0000_001F, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{32'hDEAD_BEEF, 32'h0000_0001, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
        '{32'h0001_2345, 32'h0000_FFFF, 32'h0000_0002, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'h0, 1'b0},
        '{32'h8000_0000, 32'h0000_0002, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001, 1'b0, 32'h0, 1'b0}
    };

    t_power_result pending_powers [$];
    t_power_result got_power;
    t_power_result want_power;

    int unsigned mismatches       = 0;
    int unsigned powers_checked   = 0;
    int unsigned bad_modulus_seen = 0;
    int unsigned requests_sent    = 0;
    int unsigned cycle_count      = 0;
    int unsigned rsp_stall_left   = 0;
    bit          rsp_quiet        = 1'b0;

    // Exact right-to-left square-and-multiply; products fit in 64 bits
    function automatic t_power_result predict_power(t_word b, t_word e, t_word m);
        t_power_result r;
        bit [63:0]     acc;
        bit [63:0]     sq;
        bit [63:0]     m64;
        r.power_mod   = '0;
        r.bad_modulus = 1'b1;
        if (m == '0) begin
            return r;
        end
        m64 = {32'h0, m};
        acc = 64'd1 % m64;
        sq  = {32'h0, b} % m64;
        for (int i = 0; i < EXP_BITS; i++) begin
            if (e[i]) begin
                acc = (acc * sq) % m64;
            end
            sq = (sq * sq) % m64;
        end
        r.power_mod   = acc[FIELD_BITS-1:0];
        r.bad_modulus = 1'b0;
        return r;
    endfunction

    // Random request, weighted toward the interesting corners
    function automatic t_power_row random_power_row();
        t_power_row  row;
        int unsigned pick;
        row = '0;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            row.modulus = '0;
        end else if (pick < 8) begin
            row.modulus = 32'd1;
        end else if (pick < 20) begin
            row.modulus = $urandom_range(2, 1000);
        end else if (pick < 30) begin
            row.modulus = {1'b1, 31'($urandom)};
        end else begin
            row.modulus = $urandom;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            row.exponent = '0;
        end else if (pick < 15) begin
            row.exponent = $urandom_range(1, 64);
        end else if (pick < 25) begin
            row.exponent = $urandom_range(1, 16'hFFFF);
        end else begin
            row.exponent = $urandom;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            row.base = '0;
        end else if (pick < 10) begin
            row.base = '1;
        end else if (pick < 15) begin
            row.base = row.modulus - 32'd1;
        end else begin
            row.base = $urandom;
        end
        return row;
    endfunction

    // Idle cycles before a request: mostly none or short, a few long
    function automatic int unsigned pick_req_gap(bit quiet);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(20, 100);
    endfunction

    // Present one request and hold it until the transaction completes
    task automatic send_request(t_power_row row);
        t_power_result want;
        req_ch.valid    <= 1'b1;
        req_ch.base     <= row.base;
        req_ch.exponent <= row.exponent;
        req_ch.modulus  <= row.modulus;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        if (row.golden) begin
            want.power_mod   = row.golden_pow;
            want.bad_modulus = row.golden_bad;
        end else begin
            want = predict_power(row.base, row.exponent, row.modulus);
        end
        pending_powers = {pending_powers, want};
        requests_sent++;
    endtask

    // Insert the idle gap, then send
    task automatic issue_request(t_power_row row, bit quiet);
        int unsigned gap;
        gap = pick_req_gap(quiet);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        send_request(row);
    endtask

    task automatic drain_powers();
        while (pending_powers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = ~i_clk;
    end

    // Runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_powers.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Response side: random backpressure plus per-transaction checking
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got_power.power_mod   = rsp_ch.power_mod;
            got_power.bad_modulus = rsp_ch.bad_modulus;
            if (got_power.bad_modulus) begin
                bad_modulus_seen++;
            end
            if (pending_powers.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("ERROR: unexpected result power_mod=%h bad_modulus=%b",
                             got_power.power_mod, got_power.bad_modulus);
                end
            end else begin
                want_power = pending_powers.pop_front();
                powers_checked++;
                if (got_power != want_power) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("ERROR: result %0d power_mod exp=%h got=%h, %s",
                                 powers_checked, want_power.power_mod,
                                 got_power.power_mod,
                                 $sformatf("bad_modulus exp=%b got=%b",
                                           want_power.bad_modulus,
                                           got_power.bad_modulus));
                    end
                end
            end
        end
        // re-roll quiet stretches whenever cycle_count[8:0] is zero
        if (cycle_count[8:0] == '0) begin
            rsp_quiet <= ($urandom_range(0, 2) == 0);
        end
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_stall_left != 0) begin
            rsp_stall_left <= rsp_stall_left - 1;
            rsp_ch.ready   <= 1'b0;
        end else if (!rsp_quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                          : $urandom_range(0, 3);
            rsp_ch.ready   <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Stimulus
    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.base      = '0;
        req_ch.exponent  = '0;
        req_ch.modulus   = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (power_table[i]) begin
            issue_request(power_table[i], 1'b0);
        end

        // Hold off until the table has fully drained
        req_ch.valid <= 1'b0;
        drain_powers();

        // Random requests, alternating quiet and gappy stretches
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS / 2) begin
                req_ch.valid <= 1'b0;
                drain_powers();
            end
            issue_request(random_power_row(), ((n / 30) % 3) == 0);
        end
        req_ch.valid <= 1'b0;

        drain_powers();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests (%0d directed) in %0d cycles", requests_sent,
                 DIR_ROWS, cycle_count);
        $display("Checked %0d results, %0d with zero modulus, %0d mismatches",
                 powers_checked, bad_modulus_seen, mismatches);
        if (mismatches == 0 && pending_powers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== modular_exponentiation.f =====
+incdir+rtl
rtl/modexp_pkg.sv
rtl/modexp_req_if.sv
rtl/modexp_rsp_if.sv
rtl/modexp_mulmod.sv
rtl/modular_exponentiation.sv
verif/tb_modular_exponentiation.sv
